// ----- sv/json_content_field_extractor_top_assert.svh -----
// Assertion macros used by the extractor's top module.
`ifndef JSON_CONTENT_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define JSON_CONTENT_FIELD_EXTRACTOR_TOP_ASSERT_SVH

// Condition in the same cycle implies a consequence in the same cycle.
`define JCFE_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define JCFE_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/jcfe_pkg.sv -----
package jcfe_pkg;

    // Key geometry: the last byte is compared live, the rest sit in the window.
    localparam int KEY_LEN = 11;
    localparam int WIN_LEN = KEY_LEN - 1;
    localparam int MAX_RESULTS = 3;

    // The key "content":" with index 0 as the first byte of the key.
    localparam logic [KEY_LEN-1:0][7:0] KEY_BYTES = {
        8'h22, 8'h3A, 8'h22, 8'h74, 8'h6E, 8'h65, 8'h74, 8'h6E, 8'h6F, 8'h63, 8'h22
    };

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Parse phase codes.
    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_VALUE   = 2'd1;
    localparam logic [1:0] PH_CLOSED  = 2'd2;
    localparam logic [1:0] PH_STOPPED = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_NOKEY    = 2'd1;
    localparam logic [1:0] ST_UNTERM   = 2'd2;

    // Item kinds.
    localparam logic KIND_CONTENT = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] content_byte;
        logic [1:0] parse_status;
        logic       last_of_run;
    } out_word_t;

    // Parser state carried from byte to byte.
    typedef struct packed {
        logic [WIN_LEN-1:0][7:0] window;
        logic [1:0]              phase;
        logic                    esc;
        logic [1:0]              held;
    } parse_state_t;

    // Results caused by one input word.
    typedef struct packed {
        logic [1:0]                  count;
        out_word_t [MAX_RESULTS-1:0] items;
    } result_set_t;

endpackage

// ----- sv/json_content_field_extractor_top.sv -----
// Streaming extractor of the "content" string value from a JSON text, one
// byte per input word. A byte that causes one result or none is taken every
// cycle while the result side keeps up; a byte that causes more results (up to
// three: two content bytes for an unknown escape plus the status word on the
// end-of-text byte) holds off the input until its results have drained,
// because the three-entry result buffer drains one word per cycle while
// result_ready is high and takes a new byte only once it holds at most one
// word that is leaving. Content words are sent as they are decoded, before
// the status word; a consumer drops them when the status is nonzero. After
// the end-of-text byte the parser is back in its reset state. There is no clearing pass after reset.
`include "json_content_field_extractor_top_assert.svh"

module json_content_field_extractor_top
    import jcfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      text_valid,
    output logic      text_ready,
    input  in_word_t  text,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result
);

    parse_state_t                state_reg;
    parse_state_t                state_next;
    result_set_t                 results;
    out_word_t [MAX_RESULTS-1:0] buf_reg;
    out_word_t [MAX_RESULTS-1:0] buf_next;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  cnt_next;
    logic                        pop;
    logic                        accept;

    jcfe_decode u_decode (
        .state      (state_reg),
        .word       (text),
        .state_next (state_next),
        .results    (results)
    );

    // Handshakes: a new byte is taken once the buffer empties this cycle.
    assign pop          = (cnt_reg != 2'd0) && result_ready;
    assign text_ready   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && result_ready);
    assign accept       = text_valid && text_ready;
    assign result_valid = (cnt_reg != 2'd0);
    assign result       = buf_reg[0];

    // Result buffer: shift down on a pop, reload on an accepted byte.
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
        if (accept)
        begin
            buf_next = results.items;
            cnt_next = results.count;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= 2'd0;
            state_reg.window <= '0;
            state_reg.phase  <= PH_SEARCH;
            state_reg.esc    <= 1'b0;
            state_reg.held   <= ST_COMPLETE;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Result words carry no reset.
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    // An escape can only be pending inside the value.
    `JCFE_ASSERT_SAME(a_esc_in_value, clk, rst_n, state_reg.esc,
        state_reg.phase == PH_VALUE, "escape pending outside the value")

    // A lone buffered word always closes its run.
    `JCFE_ASSERT_SAME(a_tail_is_last, clk, rst_n, cnt_reg == 2'd1,
        buf_reg[0].last_of_run, "buffer tail without last_of_run")

    // A status word is always the last word of its run.
    `JCFE_ASSERT_SAME(a_status_last, clk, rst_n,
        result_valid && (result.item_kind == KIND_STATUS),
        result.last_of_run, "status word not last of run")

    // The end of a text puts the parser back into its reset state.
    `JCFE_ASSERT_NEXT(a_end_resets, clk, rst_n, accept && text.end_of_text,
        (state_reg.phase == PH_SEARCH) && !state_reg.esc && (state_reg.window == '0),
        "parser not reset after end of text")

endmodule

// ----- sv/jcfe_decode.sv -----
module jcfe_decode
    import jcfe_pkg::*;
(
    input  parse_state_t state,
    input  in_word_t     word,
    output parse_state_t state_next,
    output result_set_t  results
);

    logic             key_hit;
    logic [1:0]       n_content;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [1:0]       status;
    parse_state_t     st;
    logic [1:0]       total;

    // The key matches when the window holds its first ten bytes and the
    // current byte is its last.
    always_comb
    begin
        key_hit = (word.text_byte == KEY_BYTES[KEY_LEN-1]);
        for (int i = 0; i < WIN_LEN; i++)
        begin
            if (state.window[i] != KEY_BYTES[i])
            begin
                key_hit = 1'b0;
            end
        end
    end

    // Per-byte parsing: phase, escape flag, window and content bytes.
    always_comb
    begin
        st        = state;
        n_content = 2'd0;
        byte0     = word.text_byte;
        byte1     = word.text_byte;
        if (word.text_byte == CH_NUL)
        begin
            if (state.phase == PH_SEARCH)
            begin
                st.held  = ST_NOKEY;
                st.phase = PH_STOPPED;
            end
            else if (state.phase == PH_VALUE)
            begin
                st.held  = ST_UNTERM;
                st.phase = PH_STOPPED;
            end
            st.esc = 1'b0;
        end
        else if (state.phase == PH_SEARCH)
        begin
            if (key_hit)
            begin
                st.phase = PH_VALUE;
                st.esc   = 1'b0;
            end
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                st.window[i] = state.window[i+1];
            end
            st.window[WIN_LEN-1] = word.text_byte;
        end
        else if (state.phase == PH_VALUE)
        begin
            if (state.esc)
            begin
                st.esc    = 1'b0;
                n_content = 2'd1;
                case (word.text_byte)
                    CH_N:     byte0 = CH_LF;
                    CH_R:     byte0 = CH_CR;
                    CH_T:     byte0 = CH_TAB;
                    CH_QUOTE: byte0 = CH_QUOTE;
                    CH_BSL:   byte0 = CH_BSL;
                    default:
                    begin
                        // Unknown escape: backslash, then the byte itself.
                        byte0     = CH_BSL;
                        n_content = 2'd2;
                    end
                endcase
            end
            else if (word.text_byte == CH_BSL)
            begin
                st.esc = 1'b1;
            end
            else if (word.text_byte == CH_QUOTE)
            begin
                st.phase = PH_CLOSED;
            end
            else
            begin
                n_content = 2'd1;
            end
        end
    end

    // Final status follows the phase reached after this byte.
    always_comb
    begin
        case (st.phase)
            PH_SEARCH: status = ST_NOKEY;
            PH_VALUE:  status = ST_UNTERM;
            PH_CLOSED: status = ST_COMPLETE;
            default:   status = st.held;
        endcase
    end

    // Assemble the result words and the state for the next byte.
    always_comb
    begin
        results.items[0] = '{KIND_CONTENT, byte0, ST_COMPLETE, 1'b0};
        results.items[1] = '{KIND_CONTENT, byte1, ST_COMPLETE, 1'b0};
        results.items[2] = '{KIND_STATUS, 8'h00, status, 1'b0};
        total            = n_content;
        state_next       = st;
        if (word.end_of_text)
        begin
            total = n_content + 2'd1;
            // The status word takes the first free slot.
            if (n_content == 2'd0)
            begin
                results.items[0] = '{KIND_STATUS, 8'h00, status, 1'b0};
            end
            else if (n_content == 2'd1)
            begin
                results.items[1] = '{KIND_STATUS, 8'h00, status, 1'b0};
            end
            state_next.window = '0;
            state_next.phase  = PH_SEARCH;
            state_next.esc    = 1'b0;
            state_next.held   = ST_COMPLETE;
        end
        if (total == 2'd1)
        begin
            results.items[0].last_of_run = 1'b1;
        end
        else if (total == 2'd2)
        begin
            results.items[1].last_of_run = 1'b1;
        end
        else if (total == 2'd3)
        begin
            results.items[2].last_of_run = 1'b1;
        end
        results.count = total;
    end

endmodule
